// File: src/first_fit_aligned_allocator_assert.svh
// Assertion macros for the first-fit allocator checker.
// Included by the checker file; depends on nothing else.
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FFA_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FFA_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: src/ffa_pkg.sv
// Package for the first-fit aligned allocator: payload types, status codes,
// controller commands and the status bundle. No dependencies.
`default_nettype none
package ffa_pkg;
  localparam int unsigned FreeSlots = 16;
  localparam int unsigned IdxW = $clog2(FreeSlots);
  localparam int unsigned CntW = $clog2(FreeSlots + 1);

  localparam logic [1:0] StGranted = 2'd0;
  localparam logic [1:0] StNofit = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic CfgPoolBase = 1'b0;
  localparam logic CfgPoolLength = 1'b1;

  typedef struct packed {
    logic [63:0] req_size;
    logic [5:0]  align_log2;
  } ffa_req_t;

  typedef struct packed {
    logic [63:0] alloc_address;
    logic [1:0]  status;
  } ffa_rsp_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load_pool;  // reload table from pool registers
    logic take_req;   // latch request
    logic scan_clr;   // scan pointer to zero
    logic scan_inc;   // advance scan pointer
    logic carve;      // write carved/split entry at scan pointer
    logic shift_up;   // move entry sh-1 to sh, decrement sh
    logic shift_dn;   // move entry sh+1 to sh, increment sh
    logic sh_ins;     // shift pointer to count (insert)
    logic sh_del;     // shift pointer to scan (delete)
    logic put_rest;   // write remainder at scan+1, count++
    logic drop_last;  // clear last entry, count--
    logic rsp_grant;  // load response: granted
    logic rsp_nofit;  // load response: no fit
    logic rsp_full;   // load response: table full
    logic rsp_zero;   // load response: zero-size grant
  } ffa_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic size_zero;
    logic scan_end;   // scan pointer is at the last valid entry (or the table is empty)
    logic fits;       // current entry fits
    logic front;      // aligned start equals entry start
    logic rest_zero;  // nothing remains after the block
    logic full;       // table holds all slots
    logic ins_done;   // shift pointer reached scan+1
    logic del_done;   // shift pointer reached count-1
  } ffa_sts_t;
endpackage
`default_nettype wire

// File: src/ffa_datapath.sv
// Extent table, request registers and fit arithmetic of the allocator.
// Depends on ffa_pkg.
`default_nettype none
module ffa_datapath import ffa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire ffa_req_t    req_i,
  input  wire ffa_cmd_t    cmd_i,
  output ffa_sts_t         sts_o,
  output ffa_rsp_t         rsp_o
);
  logic [63:0] base_q, len_q;
  logic [63:0] base_d, len_d;
  logic [63:0] st_q [FreeSlots];
  logic [63:0] ln_q [FreeSlots];
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] scan_q, sh_q;
  logic [63:0] size_q, mask_q;
  ffa_rsp_t rsp_q;

  logic [63:0] s, l, aligned, offset, rest;
  logic [64:0] sum;
  logic        wrap;
  logic [CntW-1:0] scan_w, sh_w;

  assign s = st_q[scan_q];
  assign l = ln_q[scan_q];
  assign sum = {1'b0, s} + {1'b0, mask_q};
  assign wrap = sum[64];
  assign aligned = sum[63:0] & ~mask_q;
  assign offset = aligned - s;
  assign rest = l - offset - size_q;
  assign scan_w = CntW'(scan_q);
  assign sh_w = CntW'(sh_q);

  always_comb begin
    sts_o.size_zero = (size_q == 64'd0);
    sts_o.scan_end = ((scan_w + CntW'(1)) >= cnt_q);
    sts_o.fits = !wrap && (offset <= l) && ((l - offset) >= size_q);
    sts_o.front = (offset == 64'd0);
    sts_o.rest_zero = (rest == 64'd0);
    sts_o.full = (cnt_q >= CntW'(FreeSlots));
    sts_o.ins_done = (sh_w <= scan_w + CntW'(1));
    sts_o.del_done = (sh_w + CntW'(1) >= cnt_q);
  end

  // The table reload on a write uses the value being written.
  always_comb begin
    base_d = base_q;
    len_d = len_q;
    if (cfg_we_i) begin
      if (cfg_index_i == CfgPoolBase) base_d = cfg_data_i;
      else len_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 64'd0;
      len_q <= '1;
    end else begin
      base_q <= base_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(1);
      scan_q <= '0;
      sh_q <= '0;
      for (int i = 0; i < FreeSlots; i++) begin
        st_q[i] <= 64'd0;
        ln_q[i] <= (i == 0) ? '1 : 64'd0;
      end
    end else begin
      if (cmd_i.load_pool) begin
        cnt_q <= CntW'(1);
        for (int i = 1; i < FreeSlots; i++) begin
          st_q[i] <= 64'd0;
          ln_q[i] <= 64'd0;
        end
        st_q[0] <= base_d;
        ln_q[0] <= len_d;
      end
      if (cmd_i.scan_clr) scan_q <= '0;
      if (cmd_i.scan_inc) scan_q <= scan_q + IdxW'(1);
      if (cmd_i.sh_ins) sh_q <= cnt_q[IdxW-1:0];
      if (cmd_i.sh_del) sh_q <= scan_q;
      if (cmd_i.carve) begin
        if (offset == 64'd0) begin
          st_q[scan_q] <= s + size_q;
          ln_q[scan_q] <= rest;
        end else begin
          ln_q[scan_q] <= offset;
        end
      end
      if (cmd_i.shift_up) begin
        st_q[sh_q] <= st_q[sh_q - IdxW'(1)];
        ln_q[sh_q] <= ln_q[sh_q - IdxW'(1)];
        sh_q <= sh_q - IdxW'(1);
      end
      if (cmd_i.shift_dn) begin
        st_q[sh_q] <= st_q[sh_q + IdxW'(1)];
        ln_q[sh_q] <= ln_q[sh_q + IdxW'(1)];
        sh_q <= sh_q + IdxW'(1);
      end
      if (cmd_i.put_rest) begin
        st_q[scan_q + IdxW'(1)] <= aligned + size_q;
        ln_q[scan_q + IdxW'(1)] <= rest;
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.drop_last) begin
        st_q[sh_q] <= 64'd0;
        ln_q[sh_q] <= 64'd0;
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      size_q <= req_i.req_size;
      mask_q <= ~(64'hFFFF_FFFF_FFFF_FFFF << req_i.align_log2);
    end
    if (cmd_i.rsp_grant) rsp_q <= '{alloc_address: aligned, status: StGranted};
    if (cmd_i.rsp_nofit) rsp_q <= '{alloc_address: 64'd0, status: StNofit};
    if (cmd_i.rsp_full) rsp_q <= '{alloc_address: 64'd0, status: StFull};
    if (cmd_i.rsp_zero) rsp_q <= '{alloc_address: 64'd0, status: StGranted};
  end

  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

// File: src/ffa_ctrl.sv
// Controller state machine of the allocator: scan, carve, shift, respond.
// Depends on ffa_pkg.
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  ffa_sts_t  sts_i,
  output ffa_cmd_t  cmd_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SStart = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SIns = 3'd3;
  localparam logic [2:0] SDel = 3'd4;
  localparam logic [2:0] SOut = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.load_pool = cfg_we_i;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.take_req = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = SStart;
        end
      end
      SStart: begin
        if (sts_i.size_zero) begin
          cmd_o.rsp_zero = 1'b1;
          state_d = SOut;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (!sts_i.fits) begin
          if (sts_i.scan_end) begin
            cmd_o.rsp_nofit = 1'b1;
            state_d = SOut;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end else if (sts_i.front) begin
          cmd_o.carve = 1'b1;
          cmd_o.rsp_grant = 1'b1;
          if (sts_i.rest_zero) begin
            cmd_o.sh_del = 1'b1;
            state_d = SDel;
          end else begin
            state_d = SOut;
          end
        end else if (sts_i.rest_zero) begin
          cmd_o.carve = 1'b1;
          cmd_o.rsp_grant = 1'b1;
          state_d = SOut;
        end else if (sts_i.full) begin
          cmd_o.rsp_full = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.sh_ins = 1'b1;
          state_d = SIns;
        end
      end
      SIns: begin
        if (sts_i.ins_done) begin
          cmd_o.put_rest = 1'b1;
          cmd_o.carve = 1'b1;
          cmd_o.rsp_grant = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.shift_up = 1'b1;
        end
      end
      SDel: begin
        if (sts_i.del_done) begin
          cmd_o.drop_last = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.shift_dn = 1'b1;
        end
      end
      SOut: begin
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// File: src/first_fit_aligned_allocator.sv
// First-fit aligned allocator. One transaction at a time: no request is
// accepted until the previous result has left. The controller scans the
// table entry by entry, then shifts entries to insert or delete one;
// a zero size is granted without a scan.
// Asynchronous active-low reset loads the table with the single extent
// (0, 2^64-1); a register write reloads it from the pool registers.
`default_nettype none
module first_fit_aligned_allocator import ffa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ffa_req_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ffa_rsp_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  // The controller walks the table; the datapath holds it and does the math.
  ffa_cmd_t cmd;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_data_o)
  );
endmodule
`default_nettype wire

// File: src/ffa_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on ffa_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_aligned_allocator_assert.svh"
module ffa_checker import ffa_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire ffa_rsp_t out_data_o
);
  `FFA_ASSERT_IMP(a_status_legal, clk_i, rst_ni, out_valid_o, out_data_o.status != StFull + 2'd1)
  `FFA_ASSERT_IMP(a_refused_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != StGranted, out_data_o.alloc_address == 64'd0)
  `FFA_ASSERT_IMP(a_busy_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `FFA_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `FFA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind first_fit_aligned_allocator ffa_checker u_ffa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the first-fit aligned allocator: directed and random allocation
// transactions checked against a behavioral model of the free-extent table.
// Depends on ffa_pkg and first_fit_aligned_allocator.
`default_nettype none
module tb;
  import ffa_pkg::*;

  localparam int unsigned Slots = FreeSlots;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ffa_req_t    in_data;
  logic        out_valid;
  logic        out_stall;
  ffa_rsp_t    out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  first_fit_aligned_allocator dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  // Shadow of the pool registers and the free-extent table.
  logic [63:0] pool_base_q;
  logic [63:0] pool_len_q;
  logic [63:0] ext_start[Slots];
  logic [63:0] ext_len[Slots];
  int unsigned ext_count;

  // Responses that the block still owes, oldest first.
  ffa_rsp_t    pending_rsp[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned rsp_count;
  int unsigned grant_count;
  int unsigned nofit_count;
  int unsigned full_count;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The table is reloaded with the single pool extent on reset and on any write.
  task automatic reload_table();
    for (int i = 0; i < Slots; i++) begin
      ext_start[i] = '0;
      ext_len[i] = '0;
    end
    ext_start[0] = pool_base_q;
    ext_len[0] = pool_len_q;
    ext_count = 1;
  endtask

  // First-fit walk: it updates the shadow table and returns the response.
  function automatic ffa_rsp_t allocate(ffa_req_t req);
    ffa_rsp_t    rsp;
    logic [63:0] mask;
    logic [63:0] s;
    logic [63:0] l;
    logic [63:0] aligned;
    logic [63:0] offset;
    logic [63:0] rest;
    rsp.alloc_address = '0;
    rsp.status = StNofit;
    mask = (64'd1 << req.align_log2) - 64'd1;
    if (req.req_size == 0) begin
      rsp.status = StGranted;
      return rsp;
    end
    for (int i = 0; i < ext_count; i++) begin
      s = ext_start[i];
      l = ext_len[i];
      // Rounding up must not pass the top of the address space.
      if (s > ~mask) continue;
      aligned = (s + mask) & ~mask;
      offset = aligned - s;
      if (offset > l || l - offset < req.req_size) continue;
      rest = l - offset - req.req_size;
      if (offset == 0) begin
        ext_start[i] = s + req.req_size;
        ext_len[i] = rest;
        if (rest == 0) begin
          for (int j = i; j + 1 < ext_count; j++) begin
            ext_start[j] = ext_start[j + 1];
            ext_len[j] = ext_len[j + 1];
          end
          ext_count--;
          ext_start[ext_count] = '0;
          ext_len[ext_count] = '0;
        end
      end else begin
        if (rest != 0) begin
          // A split into a full table is refused and the walk stops here.
          if (ext_count >= Slots) begin
            rsp.status = StFull;
            return rsp;
          end
          for (int j = ext_count; j > i + 1; j--) begin
            ext_start[j] = ext_start[j - 1];
            ext_len[j] = ext_len[j - 1];
          end
          ext_start[i + 1] = aligned + req.req_size;
          ext_len[i + 1] = rest;
          ext_count++;
        end
        ext_len[i] = offset;
      end
      rsp.alloc_address = aligned;
      rsp.status = StGranted;
      return rsp;
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch in %s at response %0d: got %h, expected %h",
             what, rsp_count, got, want);
  endtask

  // Sends one request after a random gap; the prediction is made on acceptance.
  // Valid stays high after acceptance so a back-to-back request needs no
  // second assignment in the same time step; wait_drained drops it.
  task automatic send_request(logic [63:0] size, logic [5:0] align);
    ffa_req_t    req;
    int unsigned gap;
    req.req_size = size;
    req.align_log2 = align;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(allocate(req));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    // Then idle before anything changes the pool.
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(logic idx, logic [63:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgPoolBase) pool_base_q = value;
    else pool_len_q = value;
    reload_table();
    @(posedge clk);
  endtask

  task automatic set_pool(logic [63:0] base, logic [63:0] len);
    write_reg(CfgPoolBase, base);
    write_reg(CfgPoolLength, len);
  endtask

  // Response side: random stall per transaction, compare each field.
  initial begin
    ffa_rsp_t    want;
    int unsigned gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 11);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        error_count++;
        $display("unexpected response %0d: %h", rsp_count, out_data);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.alloc_address !== want.alloc_address)
          report_mismatch("alloc_address", out_data.alloc_address, want.alloc_address);
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        case (want.status)
          StGranted: grant_count++;
          StNofit: nofit_count++;
          default: full_count++;
        endcase
      end
    end
  end

  // Watchdog: too long without any handshake or register write ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Extremes of both fields on the reset pool, including zero size and the largest size.
  task automatic test_field_extremes();
    send_request(64'd0, 6'd0);
    send_request(64'd0, 6'd63);
    send_request(64'd1, 6'd0);
    send_request(64'd1, 6'd63);
    send_request(64'd16, 6'd4);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
    send_request(64'h8000_0000_0000_0000, 6'd63);
    send_request(64'd5, 6'd62);
  endtask

  // A small odd pool: splits until the table is full, then exact fits.
  task automatic test_split_and_full();
    set_pool(64'd1, 64'd100000);
    for (int i = 0; i < 18; i++) send_request(64'd1, 6'(1 + (i % 3)));
    send_request(64'd3, 6'd0);
    send_request(64'd1, 6'd0);
  endtask

  // An empty pool refuses everything nonzero; a zero size still succeeds.
  task automatic test_empty_pool();
    set_pool(64'd4096, 64'd0);
    send_request(64'd1, 6'd0);
    send_request(64'd0, 6'd5);
  endtask

  // A pool that runs past the top of the address space: alignment and address wrap.
  task automatic test_wrap();
    set_pool(64'hFFFF_FFFF_FFFF_FF00, 64'h1000);
    send_request(64'd16, 6'd12);
    send_request(64'h80, 6'd8);
    send_request(64'h100, 6'd4);
    send_request(64'h10, 6'd0);
  endtask

  // Random requests; small pools and sizes keep the walk deep in the table.
  task automatic test_random(int unsigned count);
    logic [63:0] size;
    logic [5:0]  align;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: set_pool({$urandom, $urandom}, {$urandom, $urandom});
          1: set_pool(64'($urandom_range(0, 4095)), 64'($urandom_range(1000, 20000)));
          2: set_pool(64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 8000)),
                      64'($urandom_range(0, 20000)));
          default: set_pool(64'($urandom_range(0, 255)), 64'hFFFF_FFFF_FFFF_FFFF);
        endcase
      end
      // Once, halfway through, let the block drain completely before the next request.
      if (i == count / 2) wait_drained();
      case ($urandom_range(0, 9))
        0: size = {$urandom, $urandom};
        1: size = 64'd0;
        default: size = 64'($urandom_range(1, 300));
      endcase
      align = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
      send_request(size, align);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CfgPoolBase;
    cfg_data = '0;
    error_count = 0;
    sent_count = 0;
    rsp_count = 0;
    grant_count = 0;
    nofit_count = 0;
    full_count = 0;
    idle_cycles = 0;
    pool_base_q = '0;
    pool_len_q = 64'hFFFF_FFFF_FFFF_FFFF;
    reload_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_split_and_full();
    test_empty_pool();
    test_wrap();
    test_random(760);
    wait_drained();

    $display("sent %0d requests, checked %0d responses", sent_count, rsp_count);
    $display("granted %0d, no fit %0d, table full %0d, errors %0d",
             grant_count, nofit_count, full_count, error_count);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
